### sv/guid_text_parser_core_defines.svh
// ----------------------------------------------------------------------------
// guid text parser assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef GUID_TEXT_PARSER_CORE_DEFINES_SVH
`define GUID_TEXT_PARSER_CORE_DEFINES_SVH

// same-cycle implication
`define GTP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GTP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/gtp_pkg.sv
// ----------------------------------------------------------------------------
// gtp_pkg
// types, format codes and character constants of the guid text parser
// ----------------------------------------------------------------------------
`default_nettype none

package gtp_pkg;

  // text format codes, values six and seven are not formats
  typedef enum logic [2:0] {
    FMT_PLAIN  = 3'd0,
    FMT_HYPHEN = 3'd1,
    FMT_BRACE  = 3'd2,
    FMT_PAREN  = 3'd3,
    FMT_INIT   = 3'd4,
    FMT_HALVES = 3'd5
  } gtp_format_e;

  localparam int unsigned PosW = 7;

  // literal characters
  localparam logic [7:0] ChHyphen  = 8'h2D;
  localparam logic [7:0] ChLBrace  = 8'h7B;
  localparam logic [7:0] ChRBrace  = 8'h7D;
  localparam logic [7:0] ChLParen  = 8'h28;
  localparam logic [7:0] ChRParen  = 8'h29;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChX       = 8'h78;
  localparam logic [7:0] ChComma   = 8'h2C;
  localparam logic [7:0] ChLowA    = 8'h61;
  localparam logic [7:0] ChLowF    = 8'h66;
  localparam logic [7:0] ChUpA     = 8'h41;
  localparam logic [7:0] ChUpF     = 8'h46;

  // input request
  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
  } gtp_in_t;

  // result request
  typedef struct packed {
    logic        parse_ok;
    logic [63:0] guid_upper;
    logic [63:0] guid_lower;
  } gtp_out_t;

  // per-character check result
  typedef struct packed {
    logic       mismatch;
    logic       shift;
    logic [3:0] nibble;
  } gtp_check_t;

  // text length of each format, zero for invalid codes
  function automatic logic [PosW-1:0] fmt_length(logic [2:0] fmt);
    logic [PosW-1:0] len;
    unique case (fmt)
      FMT_PLAIN:  len = 7'd32;
      FMT_HYPHEN: len = 7'd36;
      FMT_BRACE:  len = 7'd38;
      FMT_PAREN:  len = 7'd38;
      FMT_INIT:   len = 7'd68;
      FMT_HALVES: len = 7'd33;
      default:    len = 7'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

### sv/gtp_char_check.sv
// ----------------------------------------------------------------------------
// gtp_char_check
// decodes what a text position expects and checks one character against it
// ----------------------------------------------------------------------------
`default_nettype none

module gtp_char_check (
  input  logic [2:0]              fmt_i,
  input  logic [gtp_pkg::PosW-1:0] pos_i,
  input  logic [7:0]              char_i,
  output gtp_pkg::gtp_check_t     check_o
);
  import gtp_pkg::*;

  logic       want_none;
  logic       want_hex;
  logic [7:0] want_char;
  logic       is_hex;
  logic [3:0] nib;

  // expected content at this position
  always_comb begin
    want_none = 1'b0;
    want_hex  = 1'b1;
    want_char = ChZero;
    if (pos_i >= fmt_length(fmt_i)) begin
      want_none = 1'b1;
      want_hex  = 1'b0;
    end else begin
      unique case (fmt_i)
        FMT_PLAIN: begin
          want_hex = 1'b1;
        end
        FMT_HYPHEN: begin
          if (pos_i == 7'd8 || pos_i == 7'd13 || pos_i == 7'd18 || pos_i == 7'd23) begin
            want_hex  = 1'b0;
            want_char = ChHyphen;
          end
        end
        FMT_BRACE, FMT_PAREN: begin
          if (pos_i == 7'd0) begin
            want_hex  = 1'b0;
            want_char = (fmt_i == FMT_BRACE) ? ChLBrace : ChLParen;
          end else if (pos_i == 7'd37) begin
            want_hex  = 1'b0;
            want_char = (fmt_i == FMT_BRACE) ? ChRBrace : ChRParen;
          end else if (pos_i == 7'd9 || pos_i == 7'd14 || pos_i == 7'd19 ||
                       pos_i == 7'd24) begin
            want_hex  = 1'b0;
            want_char = ChHyphen;
          end
        end
        FMT_INIT: begin
          case (pos_i)
            7'd0, 7'd26: begin
              want_hex  = 1'b0;
              want_char = ChLBrace;
            end
            7'd66, 7'd67: begin
              want_hex  = 1'b0;
              want_char = ChRBrace;
            end
            7'd1, 7'd12, 7'd19, 7'd27, 7'd32, 7'd37, 7'd42, 7'd47, 7'd52,
            7'd57, 7'd62: begin
              want_hex  = 1'b0;
              want_char = ChZero;
            end
            7'd2, 7'd13, 7'd20, 7'd28, 7'd33, 7'd38, 7'd43, 7'd48, 7'd53,
            7'd58, 7'd63: begin
              want_hex  = 1'b0;
              want_char = ChX;
            end
            7'd11, 7'd18, 7'd25, 7'd31, 7'd36, 7'd41, 7'd46, 7'd51, 7'd56,
            7'd61: begin
              want_hex  = 1'b0;
              want_char = ChComma;
            end
            default: begin
              want_hex = 1'b1;
            end
          endcase
        end
        FMT_HALVES: begin
          if (pos_i == 7'd16) begin
            want_hex  = 1'b0;
            want_char = ChHyphen;
          end
        end
        default: begin
          want_none = 1'b1;
          want_hex  = 1'b0;
        end
      endcase
    end
  end

  // hex digit decode
  always_comb begin
    is_hex = 1'b1;
    nib    = 4'd0;
    priority if (char_i >= ChZero && char_i <= ChNine) begin
      nib = 4'(char_i - ChZero);
    end else if (char_i >= ChLowA && char_i <= ChLowF) begin
      nib = 4'(char_i - ChLowA + 8'd10);
    end else if (char_i >= ChUpA && char_i <= ChUpF) begin
      nib = 4'(char_i - ChUpA + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
  end

  // combine into the check result
  always_comb begin
    check_o.nibble   = nib;
    check_o.shift    = want_hex && is_hex;
    check_o.mismatch = want_none || (want_hex && !is_hex) ||
                       (!want_none && !want_hex && (char_i != want_char));
  end

endmodule

`default_nettype wire

### sv/guid_text_parser_core.sv
// ----------------------------------------------------------------------------
// guid_text_parser_core
// parses a guid text one character per request in the configured format
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  input   | in        | in_valid_i/in_stall_o | gtp_in_t  (text_char, last_char)
//  result  | out       | out_valid_o/out_stall_i | gtp_out_t (parse_ok, guid_upper/lower)
//  config  | in        | cfg_we_i             | cfg_wdata_i (text_format)
//
//  one character per cycle while not stalled; each is checked and folded into the state
//  registers in the cycle it is accepted, the result register loads on the
//  last character and shows the result the next cycle.
//  reset clears the format, position, value and error flag; no clearing pass.
//  input stalls only while the result register is full and stalled.
// ----------------------------------------------------------------------------
`default_nettype none

`include "guid_text_parser_core_defines.svh"

module guid_text_parser_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  gtp_pkg::gtp_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output gtp_pkg::gtp_out_t out_data_o
);
  import gtp_pkg::*;

  logic [2:0]      fmt_q;
  logic [PosW-1:0] pos_q, pos_d;
  logic [63:0]     upper_q, upper_d;
  logic [63:0]     lower_q, lower_d;
  logic            mis_q, mis_d;
  logic            out_valid_q, out_valid_d;
  gtp_out_t        out_q, out_d;
  gtp_check_t      check;
  logic            in_acc;
  logic            ok;
  logic [PosW:0]   pos_next;

  // handshake
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  gtp_char_check u_check (
    .fmt_i   (fmt_q),
    .pos_i   (pos_q),
    .char_i  (in_data_i.text_char),
    .check_o (check)
  );

  assign pos_next = {1'b0, pos_q} + 8'd1;
  assign ok = !mis_d && (pos_next == {1'b0, fmt_length(fmt_q)});

  // text state update
  always_comb begin
    pos_d   = pos_q;
    upper_d = upper_q;
    lower_d = lower_q;
    mis_d   = mis_q;
    if (check.mismatch) begin
      mis_d = 1'b1;
    end
    if (check.shift) begin
      upper_d = {upper_q[59:0], lower_q[63:60]};
      lower_d = {lower_q[59:0], check.nibble};
    end
    if (pos_q != {PosW{1'b1}}) begin
      pos_d = pos_next[PosW-1:0];
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (in_acc && in_data_i.last_char) begin
      out_valid_d      = 1'b1;
      out_d.parse_ok   = ok;
      out_d.guid_upper = ok ? upper_d : 64'd0;
      out_d.guid_lower = ok ? lower_d : 64'd0;
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q       <= FMT_PLAIN;
      pos_q       <= '0;
      upper_q     <= '0;
      lower_q     <= '0;
      mis_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        fmt_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        if (in_data_i.last_char) begin
          pos_q   <= '0;
          upper_q <= '0;
          lower_q <= '0;
          mis_q   <= 1'b0;
        end else begin
          pos_q   <= pos_d;
          upper_q <= upper_d;
          lower_q <= lower_d;
          mis_q   <= mis_d;
        end
      end
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // assertions
  `GTP_ASSERT_NXT(a_last_gives_result, in_acc && in_data_i.last_char, out_valid_q,
                  "last character did not produce a result")
  `GTP_ASSERT_NXT(a_last_clears_state, in_acc && in_data_i.last_char,
                  pos_q == '0 && !mis_q && upper_q == '0 && lower_q == '0,
                  "text state not cleared after last character")
  `GTP_ASSERT_IMP(a_fail_zero_value, out_valid_q && !out_q.parse_ok,
                  out_q.guid_upper == 64'd0 && out_q.guid_lower == 64'd0,
                  "failed parse carries a nonzero value")
  `GTP_ASSERT_NXT(a_mismatch_sticks, in_acc && !in_data_i.last_char && check.mismatch,
                  mis_q, "mismatch flag lost within a text")

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// guid text parser testbench
// feeds guid texts one character per request in every format, correct ones
// and broken ones, and checks each parse result against a local model of the
// parser; both channels idle and stall at random, the result side once holds
// off long enough for the input to back up
// ----------------------------------------------------------------------------
module testbench;
  import gtp_pkg::*;

  // format codes that select no format
  localparam logic [2:0] FmtNone6 = 3'd6;
  localparam logic [2:0] FmtNone7 = 3'd7;

  localparam int MinChars   = 1100;
  localparam int HoldCycles = 400;
  localparam int SwapAt     = 20;
  localparam int MaxReports = 10;
  localparam int LimitNs    = 5_000_000;

  typedef enum logic [1:0] {POS_HEX, POS_LIT, POS_NONE} pos_kind_e;

  typedef enum logic [3:0] {
    TX_VALID,
    TX_ZEROS,
    TX_ONES_UP,
    TX_ONES_LOW,
    TX_LONG,
    TX_RUNON,
    TX_SHORT,
    TX_BAD_LIT,
    TX_BAD_HEX,
    TX_SHORT_BYTE,
    TX_FMT_SWAP,
    TX_NOISE
  } text_kind_e;

  typedef struct packed {
    logic [2:0] fmt;
    text_kind_e kind;
    logic       typed;
    gtp_out_t   result;
  } text_row_t;

  localparam gtp_out_t ResFail = '{parse_ok: 1'b0, guid_upper: '0, guid_lower: '0};
  localparam gtp_out_t ResZero = '{parse_ok: 1'b1, guid_upper: '0, guid_lower: '0};
  localparam gtp_out_t ResOnes = '{parse_ok: 1'b1, guid_upper: '1, guid_lower: '1};

  // directed texts, the result is typed in where it is obvious
  localparam int DirRows = 21;
  localparam text_row_t DirTable [DirRows] = '{
    '{FMT_PLAIN,  TX_ZEROS,      1'b1, ResZero},  // format after reset
    '{FMT_PLAIN,  TX_ONES_UP,    1'b1, ResOnes},
    '{FMT_PLAIN,  TX_ONES_LOW,   1'b1, ResOnes},
    '{FMT_PLAIN,  TX_VALID,      1'b0, ResFail},
    '{FMT_PLAIN,  TX_BAD_HEX,    1'b1, ResFail},
    '{FMT_HYPHEN, TX_VALID,      1'b0, ResFail},
    '{FMT_HYPHEN, TX_SHORT,      1'b1, ResFail},
    '{FMT_HYPHEN, TX_BAD_LIT,    1'b1, ResFail},
    '{FMT_BRACE,  TX_VALID,      1'b0, ResFail},
    '{FMT_BRACE,  TX_FMT_SWAP,   1'b0, ResFail},  // switches to parentheses
    '{FMT_PAREN,  TX_VALID,      1'b0, ResFail},
    '{FMT_PAREN,  TX_BAD_LIT,    1'b1, ResFail},
    '{FMT_INIT,   TX_VALID,      1'b0, ResFail},
    '{FMT_INIT,   TX_ZEROS,      1'b1, ResZero},
    '{FMT_INIT,   TX_SHORT_BYTE, 1'b1, ResFail},
    '{FMT_HALVES, TX_VALID,      1'b0, ResFail},
    '{FMT_HALVES, TX_ONES_LOW,   1'b1, ResOnes},
    '{FMT_HALVES, TX_LONG,       1'b1, ResFail},
    '{FMT_HALVES, TX_RUNON,      1'b1, ResFail},
    '{FmtNone6,   TX_NOISE,      1'b1, ResFail},
    '{FmtNone7,   TX_NOISE,      1'b1, ResFail}
  };

  logic     clk_i;
  logic     rst_ni    = 1'b0;
  logic     cfg_we    = 1'b0;
  logic [2:0] cfg_wdata = '0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  gtp_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  gtp_out_t out_data;

  // parser shadow state
  logic [2:0]   fmt_shadow = FMT_PLAIN;
  logic [6:0]   text_pos   = '0;
  logic [127:0] guid_acc   = '0;
  logic         text_bad   = 1'b0;
  gtp_out_t     pending_guids[$];

  logic [7:0] text_q[$];
  int  chars_sent   = 0;
  int  texts_sent   = 0;
  int  results_seen = 0;
  int  ok_seen      = 0;
  int  errors       = 0;
  bit  idle_on      = 1'b1;
  bit  calm         = 1'b0;
  bit  hold_req     = 1'b0;
  bit  hold_done    = 1'b0;
  logic [7:0] fmt_seen = '0;

  guid_text_parser_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // text length per format, zero where the code is no format
  function automatic int text_len(input logic [2:0] f);
    case (f)
      FMT_PLAIN:            return 32;
      FMT_HYPHEN:           return 36;
      FMT_BRACE, FMT_PAREN: return 38;
      FMT_INIT:             return 68;
      FMT_HALVES:           return 33;
      default:              return 0;
    endcase
  endfunction

  // what a position of the text must hold
  function automatic pos_kind_e char_kind(input logic [2:0] f, input logic [6:0] p,
                                          output logic [7:0] lit);
    int q;
    q = int'(p);
    lit = '0;
    if (q >= text_len(f)) return POS_NONE;
    case (f)
      FMT_HYPHEN: begin
        if (q == 8 || q == 13 || q == 18 || q == 23) begin
          lit = ChHyphen;
          return POS_LIT;
        end
      end
      FMT_BRACE, FMT_PAREN: begin
        if (q == 0) lit = (f == FMT_BRACE) ? ChLBrace : ChLParen;
        else if (q == 37) lit = (f == FMT_BRACE) ? ChRBrace : ChRParen;
        else if (q == 9 || q == 14 || q == 19 || q == 24) lit = ChHyphen;
        if (lit != '0) return POS_LIT;
      end
      FMT_INIT: begin
        if (q == 0 || q == 26) lit = ChLBrace;
        else if (q == 66 || q == 67) lit = ChRBrace;
        else if (q < 26) begin
          if (q == 1 || q == 12 || q == 19) lit = ChZero;
          else if (q == 2 || q == 13 || q == 20) lit = ChX;
          else if (q == 11 || q == 18 || q == 25) lit = ChComma;
        end else begin
          case ((q - 27) % 5)
            0: lit = ChZero;
            1: lit = ChX;
            4: lit = ChComma;
            default: lit = '0;
          endcase
        end
        if (lit != '0) return POS_LIT;
      end
      FMT_HALVES: begin
        if (q == 16) begin
          lit = ChHyphen;
          return POS_LIT;
        end
      end
      default: ;
    endcase
    return POS_HEX;
  endfunction

  // {is hex, nibble}
  function automatic logic [4:0] decode_hex(input logic [7:0] c);
    if (c >= ChZero && c <= ChNine) return {1'b1, 4'(c - ChZero)};
    if (c >= ChLowA && c <= ChLowF) return {1'b1, 4'(c - ChLowA + 8'd10)};
    if (c >= ChUpA && c <= ChUpF) return {1'b1, 4'(c - ChUpA + 8'd10)};
    return '0;
  endfunction

  function automatic logic [7:0] rand_hex_char();
    logic [3:0] n;
    n = 4'($urandom_range(0, 15));
    if (n < 4'd10) return ChZero + 8'(n);
    return ($urandom_range(0, 1) ? ChUpA : ChLowA) + 8'(n - 4'd10);
  endfunction

  // fold one accepted character into the shadow state
  task automatic track_char(input logic [7:0] ch, input logic lst, input logic typed,
                            input gtp_out_t typed_res);
    pos_kind_e  pk;
    logic [7:0] lit;
    logic [4:0] hx;
    logic [6:0] at;
    gtp_out_t   res;
    at = text_pos;
    pk = char_kind(fmt_shadow, at, lit);
    hx = decode_hex(ch);
    case (pk)
      POS_NONE: text_bad = 1'b1;
      POS_LIT:  if (ch != lit) text_bad = 1'b1;
      default: begin
        if (hx[4]) guid_acc = {guid_acc[123:0], hx[3:0]};
        else text_bad = 1'b1;
      end
    endcase
    if (text_pos != 7'd127) text_pos = text_pos + 7'd1;
    if (lst) begin
      res.parse_ok   = !text_bad && (int'(at) + 1 == text_len(fmt_shadow));
      res.guid_upper = res.parse_ok ? guid_acc[127:64] : '0;
      res.guid_lower = res.parse_ok ? guid_acc[63:0] : '0;
      pending_guids.push_back(typed ? typed_res : res);
      text_pos = '0;
      guid_acc = '0;
      text_bad = 1'b0;
      texts_sent++;
    end
  endtask

  // one character request, with an occasional gap before it
  task automatic send_char(input logic [7:0] ch, input logic lst, input logic typed,
                           input gtp_out_t typed_res);
    if (idle_on && !calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{text_char: ch, last_char: lst};
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    track_char(ch, lst, typed, typed_res);
    chars_sent++;
  endtask

  // wait for every result, then let the last character settle
  task automatic drain();
    while (pending_guids.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_format(input logic [2:0] f);
    in_valid <= 1'b0;
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= f;
    @(posedge clk_i);
    fmt_shadow = f;
    fmt_seen[f] = 1'b1;
    cfg_we <= 1'b0;
  endtask

  // text of a format, correct or broken as the kind says
  task automatic build_text(input logic [2:0] f, input text_kind_e kind);
    int         len;
    int         spots[$];
    int         p;
    logic [7:0] lit;
    logic [7:0] b;
    pos_kind_e  want;
    text_q.delete();
    len = text_len(f);
    if (len == 0 || kind == TX_NOISE) begin
      repeat ($urandom_range(1, 72)) text_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    for (p = 0; p < len; p++) begin
      if (char_kind(f, 7'(p), lit) == POS_LIT) text_q.push_back(lit);
      else begin
        case (kind)
          TX_ZEROS:    text_q.push_back(ChZero);
          TX_ONES_UP:  text_q.push_back(ChUpF);
          TX_ONES_LOW: text_q.push_back(ChLowF);
          default:     text_q.push_back(rand_hex_char());
        endcase
      end
    end
    case (kind)
      TX_LONG:  repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(0, 255)));
      TX_RUNON: repeat ($urandom_range(90, 110)) text_q.push_back(8'($urandom_range(0, 255)));
      TX_SHORT: repeat ($urandom_range(1, 4)) void'(text_q.pop_back());
      TX_FMT_SWAP: text_q[len-1] = ChRParen;
      TX_BAD_LIT, TX_BAD_HEX, TX_SHORT_BYTE: begin
        want = (kind == TX_BAD_LIT) ? POS_LIT : POS_HEX;
        for (p = 0; p < len; p++)
          if (char_kind(f, 7'(p), lit) == want && (f != FMT_INIT || kind != TX_SHORT_BYTE
              || p >= 27)) spots.push_back(p);
        // plain text has no literal, break a digit instead
        if (spots.size() == 0)
          for (p = 0; p < len; p++) spots.push_back(p);
        p = spots[$urandom_range(0, spots.size() - 1)];
        if (kind == TX_SHORT_BYTE) text_q.delete(p);
        else if (char_kind(f, 7'(p), lit) == POS_LIT) begin
          do b = 8'($urandom_range(0, 255)); while (b == lit);
          text_q[p] = b;
        end else begin
          do b = 8'($urandom_range(0, 255)); while (decode_hex(b) != '0);
          text_q[p] = b;
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_text(input text_kind_e kind, input logic typed,
                           input gtp_out_t typed_res);
    for (int i = 0; i < text_q.size(); i++) begin
      if (kind == TX_FMT_SWAP && i == SwapAt) set_format(FMT_PAREN);
      send_char(text_q[i], i == text_q.size() - 1, typed, typed_res);
    end
  endtask

  function automatic text_kind_e pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 62) return TX_VALID;
    if (r < 69) return TX_LONG;
    if (r < 71) return TX_RUNON;
    if (r < 78) return TX_SHORT;
    if (r < 85) return TX_BAD_LIT;
    if (r < 91) return TX_BAD_HEX;
    if (r < 95) return TX_SHORT_BYTE;
    return TX_NOISE;
  endfunction

  // stimulus
  initial begin
    int         ph;
    logic [2:0] f;
    text_row_t  row;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed texts
    for (int r = 0; r < DirRows; r++) begin
      row = DirTable[r];
      if (row.fmt != fmt_shadow) set_format(row.fmt);
      fmt_seen[row.fmt] = 1'b1;
      build_text(row.fmt, row.kind);
      send_text(row.kind, row.typed, row.result);
    end

    // random phases, one format each; from the second phase on no idling
    ph = 0;
    while (chars_sent < MinChars || ph < 2) begin
      if (ph < 6) f = 3'(ph);
      else if ($urandom_range(0, 9) == 0) f = $urandom_range(0, 1) ? FmtNone6 : FmtNone7;
      else f = 3'($urandom_range(0, 5));
      calm = (ph >= 1);
      set_format(f);
      idle_on = ($urandom_range(0, 3) != 0);
      if (ph == 0) hold_req = 1'b1;
      repeat ($urandom_range(2, 4)) begin
        build_text(f, pick_kind());
        send_text(TX_VALID, 1'b0, ResFail);
      end
      ph++;
    end

    // wind down
    in_valid <= 1'b0;
    drain();
    repeat (5) @(posedge clk_i);
    $display("ran %0d texts, %0d characters, %0d results (%0d parsed ok)",
             texts_sent, chars_sent, results_seen, ok_seen);
    $display("formats written %b, long result hold-off %0s", fmt_seen,
             hold_done ? "done" : "missed");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // result side: checks, random stalls and one long hold-off
  initial begin
    int       hold_left;
    int       stall_left;
    logic     nxt;
    gtp_out_t exp_res;
    hold_left  = 0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_data.parse_ok) ok_seen++;
        if (pending_guids.size() == 0) begin
          errors++;
          if (errors <= MaxReports)
            $display("result error %0d: unexpected result ok=%0b %h_%h", errors,
                     out_data.parse_ok, out_data.guid_upper, out_data.guid_lower);
        end else begin
          exp_res = pending_guids.pop_front();
          if (out_data.parse_ok !== exp_res.parse_ok
              || out_data.guid_upper !== exp_res.guid_upper
              || out_data.guid_lower !== exp_res.guid_lower) begin
            errors++;
            if (errors <= MaxReports)
              $display("result error %0d: expected ok=%0b %h_%h, got ok=%0b %h_%h",
                       errors, exp_res.parse_ok, exp_res.guid_upper, exp_res.guid_lower,
                       out_data.parse_ok, out_data.guid_upper, out_data.guid_lower);
          end
        end
      end
      // next stall value
      if (hold_left > 0) begin
        hold_left--;
        nxt = 1'b1;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        nxt = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt = 1'b1;
      end else if (idle_on && !calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        nxt = 1'b1;
      end else begin
        nxt = 1'b0;
      end
      out_stall <= nxt;
    end
  end

  // run limit
  initial begin
    #(LimitNs);
    $display("run limit reached with %0d results outstanding", pending_guids.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
